/* hw/rtl/itsa_pkg.sv */
// ----------------------------------------------------------------------------
// itsa_pkg
// Shared types and constants of the icon tile slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package itsa_pkg;

  localparam int ICON_COUNT_DEF = 160;
  localparam int SLOT_COUNT_DEF = 32;

  localparam int ICON_W     = 8;
  localparam int OFFSET_W   = 16;
  localparam int TILE_END_W = 10;
  localparam int TILE_W     = 16;
  localparam int SLOT_OUT_W = 5;
  localparam int COUNT_W    = 8;
  localparam int SLOT_P1_W  = 6;

  localparam logic [TILE_END_W-1:0] TILE_END_RST = 10'd1023;
  localparam logic [COUNT_W-1:0]    COUNT_MAX    = 8'd255;

  typedef enum logic [1:0] {
    CMD_GET     = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_BLANK   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [COUNT_W-1:0]   count;
    logic [SLOT_P1_W-1:0] slot_p1;
  } entry_t;

endpackage

`default_nettype wire

/* hw/rtl/icon_tile_slot_allocator_top.sv */
// ----------------------------------------------------------------------------
// icon_tile_slot_allocator_top
// Maps icon numbers to display tile slots with a saturating use count.
//
// Input channel (in_valid/in_stall) carries one command item: get, release,
// clear all or blank, with an icon number and a tile offset. Every item gives
// exactly one result item on the output channel (out_valid/out_stall).
// Per-icon count and slot live in a synchronous memory with a registered read;
// slot occupancy and per-icon valid bits sit in flip-flops.
// An item runs in two steps: the memory read, then the update and write-back.
// The result is written to the output register in the update step; a
// new item is taken only once the previous one has left the update step.
// The output register lets the next item be accepted while a result waits;
// that item then holds in the update step until the result is taken.
// Reset (rst, synchronous) empties all stores at once through the valid bits
// and sets tile_end to 1023. tile_end is written through cfg_we/cfg_data;
// the user must write it only while the block is idle, as the block has no guard for this.
// ----------------------------------------------------------------------------
`default_nettype none

module icon_tile_slot_allocator_top #(
  parameter int ICON_COUNT = itsa_pkg::ICON_COUNT_DEF,
  parameter int SLOT_COUNT = itsa_pkg::SLOT_COUNT_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_we,
  input  wire  [itsa_pkg::TILE_END_W-1:0]       cfg_data,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  [1:0]                            command,
  input  wire  [itsa_pkg::ICON_W-1:0]           icon,
  input  wire  [itsa_pkg::OFFSET_W-1:0]         tile_offset,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic [itsa_pkg::TILE_W-1:0]           tile_first,
  output logic                                  consecutive,
  output logic                                  load_request,
  output logic [itsa_pkg::SLOT_OUT_W-1:0]       slot,
  output logic                                  full_res,
  output logic [itsa_pkg::COUNT_W-1:0]          use_count
);

  localparam int IDX_W  = (ICON_COUNT > 1) ? $clog2(ICON_COUNT) : 1;
  localparam int SIDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SP1_W  = itsa_pkg::SLOT_P1_W;
  localparam int CNT_W  = itsa_pkg::COUNT_W;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  logic [itsa_pkg::TILE_END_W-1:0] tile_end;
  logic [ICON_COUNT-1:0]           vld;
  logic [SLOT_COUNT-1:0]           used;

  itsa_pkg::entry_t mem [ICON_COUNT];
  itsa_pkg::entry_t rd_q;
  logic             rd_vld_q;

  itsa_pkg::cmd_t              cmd_q;
  logic                        in_range_q;
  logic [IDX_W-1:0]            idx_q;
  logic [itsa_pkg::OFFSET_W-1:0] offset_q;

  logic             accept;
  logic             fire;
  logic             in_range;
  logic [IDX_W-1:0] idx;

  logic                 mem_we;
  itsa_pkg::entry_t     wdata;
  logic                 set_vld;
  logic                 take_slot;
  logic                 free_slot;
  logic [SIDX_W-1:0]    take_idx;
  logic [SIDX_W-1:0]    free_idx;
  logic                 do_clear;

  itsa_pkg::entry_t     cur;
  logic                 found;
  logic [SIDX_W-1:0]    low_free;
  logic [CNT_W-1:0]     cnt_inc;
  logic [SP1_W-1:0]     res_p1;
  logic [SP1_W-1:0]     slot_idx;
  logic                 res_hit;
  logic [itsa_pkg::TILE_W-1:0] tile_calc;

  logic [itsa_pkg::TILE_W-1:0]     r_tile;
  logic                            r_consec;
  logic                            r_load;
  logic [itsa_pkg::SLOT_OUT_W-1:0] r_slot;
  logic                            r_full;
  logic [CNT_W-1:0]                r_count;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign fire     = (state == S_EXEC) && (!out_valid || !out_stall);
  assign in_range = ({1'b0, icon} < (itsa_pkg::ICON_W+1)'(ICON_COUNT));
  assign idx      = icon[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q <= mem[idx];
    end
    if (mem_we && fire) begin
      mem[idx_q] <= wdata;
    end
  end

  always_comb begin
    found    = 1'b0;
    low_free = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!used[i]) begin
        found    = 1'b1;
        low_free = SIDX_W'(i);
      end
    end
  end

  always_comb begin
    cur       = rd_vld_q ? rd_q : '0;
    cnt_inc   = (cur.count == itsa_pkg::COUNT_MAX) ? cur.count : cur.count + CNT_W'(1);
    mem_we    = 1'b0;
    wdata     = cur;
    set_vld   = 1'b0;
    take_slot = 1'b0;
    take_idx  = low_free;
    free_slot = 1'b0;
    free_idx  = '0;
    do_clear  = 1'b0;
    res_p1    = '0;
    res_hit   = 1'b0;
    r_load    = 1'b0;
    r_full    = 1'b0;
    r_count   = '0;
    slot_idx  = cur.slot_p1 - SP1_W'(1);
    unique case (cmd_q)
      itsa_pkg::CMD_GET: begin
        if (!in_range_q) begin
          r_full = 1'b1;
        end else if (cur.slot_p1 != '0) begin
          mem_we        = 1'b1;
          set_vld       = 1'b1;
          wdata.count   = cnt_inc;
          res_p1        = cur.slot_p1;
          res_hit       = 1'b1;
          r_count       = cnt_inc;
        end else if (found) begin
          mem_we        = 1'b1;
          set_vld       = 1'b1;
          take_slot     = 1'b1;
          wdata.count   = cnt_inc;
          wdata.slot_p1 = SP1_W'(low_free) + SP1_W'(1);
          res_p1        = SP1_W'(low_free) + SP1_W'(1);
          res_hit       = 1'b1;
          r_load        = 1'b1;
          r_count       = cnt_inc;
        end else begin
          r_full  = 1'b1;
          r_count = cur.count;
        end
      end
      itsa_pkg::CMD_RELEASE: begin
        if (in_range_q && (cur.slot_p1 != '0)) begin
          mem_we        = 1'b1;
          set_vld       = 1'b1;
          wdata.slot_p1 = '0;
          if (cur.slot_p1 <= SP1_W'(SLOT_COUNT)) begin
            free_slot = 1'b1;
            free_idx  = slot_idx[SIDX_W-1:0];
          end
        end
      end
      itsa_pkg::CMD_CLEAR: begin
        do_clear = 1'b1;
      end
      default: begin
      end
    endcase
    tile_calc = itsa_pkg::TILE_W'(tile_end)
              - {8'b0, res_p1, 2'b00}
              + offset_q;
  end

  always_comb begin
    r_consec = res_hit;
    r_tile   = res_hit ? tile_calc : '0;
    r_slot   = res_hit ? itsa_pkg::SLOT_OUT_W'(res_p1 - SP1_W'(1)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tile_end  <= itsa_pkg::TILE_END_RST;
      vld       <= '0;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        tile_end <= cfg_data;
      end
      if (out_valid && !out_stall && !fire) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state      <= S_EXEC;
            cmd_q      <= itsa_pkg::cmd_t'(command);
            in_range_q <= in_range;
            idx_q      <= idx;
            offset_q   <= tile_offset;
            rd_vld_q   <= in_range ? vld[idx] : 1'b0;
          end
        end
        S_EXEC: begin
          if (fire) begin
            state        <= S_IDLE;
            out_valid    <= 1'b1;
            tile_first   <= r_tile;
            consecutive  <= r_consec;
            load_request <= r_load;
            slot         <= r_slot;
            full_res     <= r_full;
            use_count    <= r_count;
            if (do_clear) begin
              vld  <= '0;
              used <= '0;
            end else begin
              if (set_vld) begin
                vld[idx_q] <= 1'b1;
              end
              if (take_slot) begin
                used[take_idx] <= 1'b1;
              end
              if (free_slot) begin
                used[free_idx] <= 1'b0;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* dv/icon_tile_slot_allocator_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icon_tile_slot_allocator_top_tb
// Self-checking bench for the icon tile slot allocator. An in-bench allocation
// predictor tracks use counts, icon slots and slot owners, and each result
// item is compared against the oldest prediction. It covers directed corner
// cases, pool exhaustion, use count saturation and random traffic across
// several tile_end settings, with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------

module icon_tile_slot_allocator_top_tb;

  localparam int ICON_COUNT     = itsa_pkg::ICON_COUNT_DEF;
  localparam int SLOT_COUNT     = itsa_pkg::SLOT_COUNT_DEF;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [itsa_pkg::TILE_W-1:0]     tile_first;
    logic                            consecutive;
    logic                            load_request;
    logic [itsa_pkg::SLOT_OUT_W-1:0] slot;
    logic                            full_res;
    logic [itsa_pkg::COUNT_W-1:0]    use_count;
  } tile_result_t;

  logic                            clk         = 1'b0;
  logic                            rst         = 1'b1;
  logic                            cfg_we      = 1'b0;
  logic [itsa_pkg::TILE_END_W-1:0] cfg_data    = '0;
  logic                            in_valid    = 1'b0;
  logic [1:0]                      command     = itsa_pkg::CMD_BLANK;
  logic [itsa_pkg::ICON_W-1:0]     icon        = '0;
  logic [itsa_pkg::OFFSET_W-1:0]   tile_offset = '0;
  logic                            out_stall   = 1'b0;
  logic                            in_stall;
  logic                            out_valid;
  logic [itsa_pkg::TILE_W-1:0]     tile_first;
  logic                            consecutive;
  logic                            load_request;
  logic [itsa_pkg::SLOT_OUT_W-1:0] slot;
  logic                            full_res;
  logic [itsa_pkg::COUNT_W-1:0]    use_count;

  // allocation predictor state
  logic [itsa_pkg::COUNT_W-1:0]    icon_uses     [ICON_COUNT];
  logic [itsa_pkg::SLOT_P1_W-1:0]  icon_slot_tag [ICON_COUNT];
  logic [7:0]                      slot_holder   [SLOT_COUNT];
  logic [itsa_pkg::TILE_END_W-1:0] tile_end_shadow = itsa_pkg::TILE_END_RST;

  tile_result_t expected_tiles[$];

  int mismatch_count = 0;
  int idle_cycles    = 0;
  int burst_left     = 0;
  int gap_max        = 0;
  int stall_pct      = 0;
  int stall_max      = 1;
  int stall_hold     = 0;
  bit in_taken       = 1'b0;
  bit out_taken      = 1'b0;

  icon_tile_slot_allocator_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .icon         (icon),
    .tile_offset  (tile_offset),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .tile_first   (tile_first),
    .consecutive  (consecutive),
    .load_request (load_request),
    .slot         (slot),
    .full_res     (full_res),
    .use_count    (use_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [15:0] rand_offset();
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic void clear_allocation();
    for (int i = 0; i < ICON_COUNT; i++) begin
      icon_uses[i]     = '0;
      icon_slot_tag[i] = '0;
    end
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_holder[i] = '0;
    end
  endfunction

  function automatic tile_result_t predict_allocation(input itsa_pkg::cmd_t c,
                                                      input logic [7:0] ic,
                                                      input logic [15:0] off);
    tile_result_t r;
    int s;
    logic [15:0] span;
    r = '0;
    s = -1;
    case (c)
      itsa_pkg::CMD_GET: begin
        if (ic >= ICON_COUNT) begin
          r.full_res = 1'b1;
        end else begin
          if (icon_slot_tag[ic] != 0) begin
            s = icon_slot_tag[ic] - 1;
          end else begin
            for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
              if (slot_holder[i] == 0) s = i;
            end
            if (s >= 0) begin
              slot_holder[s]    = ic + 8'd1;
              icon_slot_tag[ic] = itsa_pkg::SLOT_P1_W'(s + 1);
              r.load_request    = 1'b1;
            end
          end
          if (s < 0) begin
            r.full_res = 1'b1;
          end else begin
            if (icon_uses[ic] != itsa_pkg::COUNT_MAX) icon_uses[ic] = icon_uses[ic] + 8'd1;
            span          = 16'((s + 1) * 4);
            r.tile_first  = {6'd0, tile_end_shadow} - span + off;
            r.consecutive = 1'b1;
            r.slot        = itsa_pkg::SLOT_OUT_W'(s);
          end
          r.use_count = icon_uses[ic];
        end
      end
      itsa_pkg::CMD_RELEASE: begin
        if (ic < ICON_COUNT) begin
          if (icon_slot_tag[ic] != 0) begin
            slot_holder[icon_slot_tag[ic] - 1] = '0;
            icon_slot_tag[ic] = '0;
          end
        end
      end
      itsa_pkg::CMD_CLEAR: clear_allocation();
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // sample both channels on the falling edge ahead of the edge that takes the item
  always @(negedge clk) begin : check_results
    tile_result_t want;
    in_taken  = !rst && in_valid && !in_stall;
    out_taken = !rst && out_valid && !out_stall;
    if (out_taken) begin
      if (expected_tiles.size() == 0) begin
        report_mismatch("result item with none pending", tile_first, '0);
      end else begin
        want = expected_tiles.pop_front();
        if (tile_first !== want.tile_first)
          report_mismatch("tile_first", tile_first, want.tile_first);
        if (consecutive !== want.consecutive)
          report_mismatch("consecutive", 16'(consecutive), 16'(want.consecutive));
        if (load_request !== want.load_request)
          report_mismatch("load_request", 16'(load_request), 16'(want.load_request));
        if (slot !== want.slot)
          report_mismatch("slot", 16'(slot), 16'(want.slot));
        if (full_res !== want.full_res)
          report_mismatch("full_res", 16'(full_res), 16'(want.full_res));
        if (use_count !== want.use_count)
          report_mismatch("use_count", 16'(use_count), 16'(want.use_count));
      end
    end
  end

  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_hold = $urandom_range(0, stall_max - 1);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (in_taken || out_taken) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic set_idling(input int gaps, input int pct, input int run);
    gap_max   = gaps;
    stall_pct = pct;
    stall_max = run;
  endtask

  task automatic send_item(input itsa_pkg::cmd_t c, input logic [7:0] ic,
                           input logic [15:0] off);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    command     <= c;
    icon        <= ic;
    tile_offset <= off;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    expected_tiles.push_back(predict_allocation(c, ic, off));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_tiles.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tile_end(input logic [itsa_pkg::TILE_END_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we          <= 1'b0;
    tile_end_shadow = value;
    @(posedge clk);
  endtask

  task automatic test_directed_cases();
    set_idling(2, 25, 3);
    send_item(itsa_pkg::CMD_GET, 8'd0, 16'h0000);
    send_item(itsa_pkg::CMD_GET, 8'd0, 16'hFFFF);
    send_item(itsa_pkg::CMD_GET, 8'd159, 16'h8000);
    send_item(itsa_pkg::CMD_GET, 8'd160, 16'h1234);
    send_item(itsa_pkg::CMD_GET, 8'd255, 16'hFFFF);
    send_item(itsa_pkg::CMD_RELEASE, 8'd0, 16'hFFFF);
    send_item(itsa_pkg::CMD_RELEASE, 8'd0, 16'h0000);
    send_item(itsa_pkg::CMD_RELEASE, 8'd200, 16'h0000);
    send_item(itsa_pkg::CMD_RELEASE, 8'd5, 16'h5555);
    send_item(itsa_pkg::CMD_GET, 8'd7, 16'h0001);
    send_item(itsa_pkg::CMD_GET, 8'd0, 16'h00FF);
    send_item(itsa_pkg::CMD_BLANK, 8'd0, 16'hFFFF);
    send_item(itsa_pkg::CMD_BLANK, 8'd255, 16'h0000);
    send_item(itsa_pkg::CMD_GET, 8'd159, 16'h5555);
    send_item(itsa_pkg::CMD_CLEAR, 8'hAA, 16'hAAAA);
    send_item(itsa_pkg::CMD_GET, 8'd0, 16'h0000);
    send_item(itsa_pkg::CMD_GET, 8'd159, 16'h7FFF);
    send_item(itsa_pkg::CMD_RELEASE, 8'd0, 16'h0000);
    send_item(itsa_pkg::CMD_GET, 8'd1, 16'hFFFC);
    send_item(itsa_pkg::CMD_CLEAR, 8'h55, 16'h5555);
    wait_drained();
  endtask

  task automatic test_pool_exhaustion();
    write_tile_end('0);
    set_idling(3, 40, 5);
    send_item(itsa_pkg::CMD_GET, 8'd142, rand_offset());
    send_item(itsa_pkg::CMD_RELEASE, 8'd142, rand_offset());
    for (int i = 0; i < SLOT_COUNT; i++) begin
      send_item(itsa_pkg::CMD_GET, 8'(100 + i), rand_offset());
    end
    send_item(itsa_pkg::CMD_GET, 8'd142, rand_offset());
    send_item(itsa_pkg::CMD_GET, 8'd140, rand_offset());
    send_item(itsa_pkg::CMD_GET, 8'd100, rand_offset());
    send_item(itsa_pkg::CMD_RELEASE, 8'd110, rand_offset());
    send_item(itsa_pkg::CMD_RELEASE, 8'd103, rand_offset());
    send_item(itsa_pkg::CMD_GET, 8'd140, rand_offset());
    send_item(itsa_pkg::CMD_GET, 8'd141, rand_offset());
    send_item(itsa_pkg::CMD_GET, 8'd142, rand_offset());
    send_item(itsa_pkg::CMD_GET, 8'd131, rand_offset());
    send_item(itsa_pkg::CMD_CLEAR, 8'd0, 16'h0000);
    wait_drained();
  endtask

  task automatic test_count_saturation();
    write_tile_end(itsa_pkg::TILE_END_RST);
    set_idling(0, 0, 1);
    for (int i = 0; i < 258; i++) begin
      send_item(itsa_pkg::CMD_GET, 8'd42, rand_offset());
    end
    send_item(itsa_pkg::CMD_RELEASE, 8'd42, 16'h0000);
    send_item(itsa_pkg::CMD_GET, 8'd42, rand_offset());
    send_item(itsa_pkg::CMD_GET, 8'd42, rand_offset());
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int spans [4];
    int pick;
    itsa_pkg::cmd_t c;
    logic [7:0] ic;
    spans = '{63, 39, 159, 47};
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_tile_end(10'd1023);
          set_idling(0, 0, 1);
        end
        1: begin
          write_tile_end(10'd0);
          set_idling(3, 30, 4);
        end
        2: begin
          write_tile_end(10'($urandom_range(0, 1023)));
          set_idling(8, 60, 12);
        end
        default: begin
          write_tile_end(10'd3);
          set_idling(1, 15, 2);
        end
      endcase
      for (int n = 0; n < 20; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 58) c = itsa_pkg::CMD_GET;
        else if (pick < 88) c = itsa_pkg::CMD_RELEASE;
        else if (pick < 90) c = itsa_pkg::CMD_CLEAR;
        else c = itsa_pkg::CMD_BLANK;
        pick = $urandom_range(0, 99);
        if (pick < 6) ic = 8'($urandom_range(ICON_COUNT, 255));
        else if (pick < 12) ic = 8'($urandom_range(0, ICON_COUNT - 1));
        else ic = 8'($urandom_range(0, spans[phase]));
        send_item(c, ic, rand_offset());
      end
      wait_drained();
    end
  endtask

  initial begin
    clear_allocation();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_pool_exhaustion();
    test_count_saturation();
    test_random_traffic();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
